>>> rtl/lcdnw_pkg.sv
// ---------------------------------------------------------------------------
// lcdnw_pkg
// Types, codes and the control store shared by the character display
// nibble writer.
// ---------------------------------------------------------------------------
package lcdnw_pkg;

    localparam int CfgIdxW   = 2;
    localparam int PcW       = 5;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_SHORT_HOLD = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_LONG_HOLD  = 2'd1;

    localparam logic [7:0] SHORT_HOLD_RST = 8'd8;
    localparam logic [7:0] LONG_HOLD_RST  = 8'd50;

    // request codes
    localparam logic [2:0] CMD_BYTE   = 3'd0;
    localparam logic [2:0] CMD_DATA   = 3'd1;
    localparam logic [2:0] CMD_CHAR   = 3'd2;
    localparam logic [2:0] CMD_LOCATE = 3'd3;
    localparam logic [2:0] CMD_INIT   = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    // character remapping
    localparam logic [7:0] CHR_SKIP  = 8'hC3;
    localparam logic [7:0] CHR_A4    = 8'hA4;
    localparam logic [7:0] CHR_B6    = 8'hB6;
    localparam logic [7:0] CHR_BC    = 8'hBC;
    localparam logic [7:0] CHR_A4_TO = 8'hE1;
    localparam logic [7:0] CHR_B6_TO = 8'hEF;
    localparam logic [7:0] CHR_BC_TO = 8'hF5;
    localparam logic [7:0] LOC_ROW0  = 8'h80;
    localparam logic [7:0] LOC_ROW1  = 8'hC0;
    localparam logic [7:0] BYTE_CLR  = 8'h01;

    // program entry points
    localparam logic [PcW-1:0] ENTRY_BYTE = 5'd0;
    localparam logic [PcW-1:0] ENTRY_INIT = 5'd4;

    // nibble source selects
    localparam logic [1:0] NSEL_CONST = 2'd0;
    localparam logic [1:0] NSEL_HI    = 2'd1;
    localparam logic [1:0] NSEL_LO    = 2'd2;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] value;
        logic       row;
        logic [3:0] column;
    } t_req;

    typedef struct packed {
        logic       reg_select;
        logic       enable_level;
        logic [3:0] nibble;
        logic [7:0] hold_ticks;
        logic       last;
    } t_phase;

    // one control word per step
    typedef struct packed {
        logic       en;
        logic [1:0] nsel;
        logic [3:0] cnib;
        logic       hold_long;
        logic       last;
    } t_uword;

    // start of a program run, handed from the decoder to the sequencer
    typedef struct packed {
        logic           go;
        logic [PcW-1:0] entry;
        logic           rs;
        logic [7:0]     byte_val;
    } t_seq_start;

    function automatic t_uword uw(logic en, logic [1:0] nsel, logic [3:0] cnib,
                                  logic hold_long, logic last);
        t_uword w;
        w.en        = en;
        w.nsel      = nsel;
        w.cnib      = cnib;
        w.hold_long = hold_long;
        w.last      = last;
        return w;
    endfunction

    // control store
    function automatic t_uword ucode(logic [PcW-1:0] pc);
        t_uword w;
        w = uw(1'b0, NSEL_CONST, 4'h0, 1'b0, 1'b1);
        unique case (pc)
            // byte program: high nibble then low nibble
            5'd0:  w = uw(1'b1, NSEL_HI, 4'h0, 1'b0, 1'b0);
            5'd1:  w = uw(1'b0, NSEL_HI, 4'h0, 1'b0, 1'b0);
            5'd2:  w = uw(1'b1, NSEL_LO, 4'h0, 1'b0, 1'b0);
            5'd3:  w = uw(1'b0, NSEL_LO, 4'h0, 1'b0, 1'b1);
            // init program
            5'd4:  w = uw(1'b0, NSEL_CONST, 4'h0, 1'b1, 1'b0);
            5'd5:  w = uw(1'b1, NSEL_CONST, 4'h3, 1'b0, 1'b0);
            5'd6:  w = uw(1'b0, NSEL_CONST, 4'h3, 1'b0, 1'b0);
            5'd7:  w = uw(1'b0, NSEL_CONST, 4'h3, 1'b0, 1'b0);
            5'd8:  w = uw(1'b1, NSEL_CONST, 4'h3, 1'b0, 1'b0);
            5'd9:  w = uw(1'b0, NSEL_CONST, 4'h3, 1'b0, 1'b0);
            5'd10: w = uw(1'b0, NSEL_CONST, 4'h3, 1'b0, 1'b0);
            5'd11: w = uw(1'b1, NSEL_CONST, 4'h3, 1'b0, 1'b0);
            5'd12: w = uw(1'b0, NSEL_CONST, 4'h3, 1'b0, 1'b0);
            5'd13: w = uw(1'b0, NSEL_CONST, 4'h3, 1'b0, 1'b0);
            5'd14: w = uw(1'b1, NSEL_CONST, 4'h2, 1'b0, 1'b0);
            5'd15: w = uw(1'b0, NSEL_CONST, 4'h2, 1'b0, 1'b0);
            5'd16: w = uw(1'b0, NSEL_CONST, 4'h2, 1'b0, 1'b0);
            5'd17: w = uw(1'b1, NSEL_CONST, 4'h0, 1'b0, 1'b0);
            5'd18: w = uw(1'b0, NSEL_CONST, 4'h0, 1'b0, 1'b0);
            5'd19: w = uw(1'b1, NSEL_CONST, 4'h1, 1'b0, 1'b0);
            5'd20: w = uw(1'b0, NSEL_CONST, 4'h1, 1'b0, 1'b0);
            5'd21: w = uw(1'b1, NSEL_CONST, 4'h2, 1'b0, 1'b0);
            5'd22: w = uw(1'b0, NSEL_CONST, 4'h2, 1'b0, 1'b0);
            5'd23: w = uw(1'b1, NSEL_CONST, 4'h8, 1'b0, 1'b0);
            5'd24: w = uw(1'b0, NSEL_CONST, 4'h8, 1'b0, 1'b0);
            5'd25: w = uw(1'b0, NSEL_CONST, 4'h8, 1'b0, 1'b0);
            5'd26: w = uw(1'b1, NSEL_CONST, 4'h0, 1'b0, 1'b0);
            5'd27: w = uw(1'b0, NSEL_CONST, 4'h0, 1'b0, 1'b0);
            5'd28: w = uw(1'b1, NSEL_CONST, 4'hF, 1'b0, 1'b0);
            5'd29: w = uw(1'b0, NSEL_CONST, 4'hF, 1'b0, 1'b0);
            5'd30: w = uw(1'b0, NSEL_CONST, 4'hF, 1'b0, 1'b1);
            default: w = uw(1'b0, NSEL_CONST, 4'h0, 1'b0, 1'b1);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/lcdnw_seq.sv
// ---------------------------------------------------------------------------
// lcdnw_seq
// Step counter over the control store, plain phase datapath and the output
// register.
// ---------------------------------------------------------------------------
module lcdnw_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lcdnw_pkg::t_seq_start i_start,
    input  logic [7:0]            i_short_hold,
    input  logic [7:0]            i_long_hold,
    output logic                  o_busy,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output lcdnw_pkg::t_phase     o_out
);
    import lcdnw_pkg::*;

    logic           r_busy;
    logic [PcW-1:0] r_pc;
    logic           r_rs;
    logic [7:0]     r_byte;
    logic           r_out_valid;
    t_phase         r_out;

    t_uword         w;
    t_phase         n_out;
    logic           adv;

    assign w   = ucode(r_pc);
    assign adv = r_busy && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out.reg_select   = r_rs;
        n_out.enable_level = w.en;
        unique case (w.nsel)
            NSEL_HI: n_out.nibble = r_byte[7:4];
            NSEL_LO: n_out.nibble = r_byte[3:0];
            default: n_out.nibble = w.cnib;
        endcase
        n_out.hold_ticks = w.hold_long ? i_long_hold : i_short_hold;
        n_out.last       = w.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= ENTRY_BYTE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_start.go) begin
                r_busy <= 1'b1;
                r_pc   <= i_start.entry;
            end else if (adv) begin
                if (w.last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pc <= r_pc + 1'b1;
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start.go) begin
            r_rs   <= i_start.rs;
            r_byte <= i_start.byte_val;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_busy      = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/char_lcd_nibble_writer_top.sv
// ---------------------------------------------------------------------------
// char_lcd_nibble_writer_top
// Turns display requests into 4-bit bus phases for a character display.
// ---------------------------------------------------------------------------
// One request beat in, a run of phase beats out. A byte request (command,
// raw data, mapped character, locate, clear) gives 4 phases; init gives 27;
// a mapped character 0xC3 and an unknown request code give none. Phases
// leave at one per clock while the output side does not stall, read one a
// cycle from the control store by the step counter, and the input stalls
// while the sequencer is busy with a request's phases; a request that gives
// no phases leaves the input free on the next cycle. The final phase sits
// in the output register while the next request is already taken. Hold
// times come from the short_hold and long_hold registers as they stand when
// the phase is produced; write them only while the block is idle. The
// configuration port is always ready.
// ---------------------------------------------------------------------------
module char_lcd_nibble_writer_top #(
    parameter logic [7:0] SHORT_HOLD_INIT = lcdnw_pkg::SHORT_HOLD_RST,
    parameter logic [7:0] LONG_HOLD_INIT  = lcdnw_pkg::LONG_HOLD_RST
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lcdnw_pkg::t_req               i_in_req,
    // phase channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lcdnw_pkg::t_phase             o_out,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lcdnw_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);
    import lcdnw_pkg::*;

    logic [7:0] r_short_hold;
    logic [7:0] r_long_hold;
    logic       busy;
    logic       in_beat;
    t_seq_start start;

    // Configuration: writes beyond the register list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_hold <= SHORT_HOLD_INIT;
            r_long_hold  <= LONG_HOLD_INIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SHORT_HOLD: r_short_hold <= i_cfg_data;
                CFG_LONG_HOLD:  r_long_hold  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the request side off while a program runs.
    assign o_in_stall = busy;
    assign in_beat    = i_in_valid && !busy;

    // Decode the request into an entry point, a register select and the
    // byte the byte program splits into nibbles.
    always_comb begin
        start.go       = in_beat;
        start.entry    = ENTRY_BYTE;
        start.rs       = 1'b0;
        start.byte_val = i_in_req.value;
        unique case (i_in_req.cmd)
            CMD_BYTE: ;
            CMD_DATA: start.rs = 1'b1;
            CMD_CHAR: begin
                start.rs = 1'b1;
                case (i_in_req.value)
                    CHR_A4:   start.byte_val = CHR_A4_TO;
                    CHR_B6:   start.byte_val = CHR_B6_TO;
                    CHR_BC:   start.byte_val = CHR_BC_TO;
                    CHR_SKIP: start.go       = 1'b0;   // drop: no phases
                    default:  ;
                endcase
            end
            CMD_LOCATE: begin
                start.byte_val = (i_in_req.row ? LOC_ROW1 : LOC_ROW0)
                               | {4'h0, i_in_req.column};
            end
            CMD_INIT:  start.entry    = ENTRY_INIT;
            CMD_CLEAR: start.byte_val = BYTE_CLR;
            default:   start.go       = 1'b0;      // unknown code: drop
        endcase
    end

    lcdnw_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_short_hold (r_short_hold),
        .i_long_hold  (r_long_hold),
        .o_busy       (busy),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out)
    );

endmodule

>>> rtl/lcdnw_checker.sv
// ---------------------------------------------------------------------------
// lcdnw_checker
// Port-level checks for the character display nibble writer.
// ---------------------------------------------------------------------------
module lcdnw_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input lcdnw_pkg::t_req   i_in_req,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input lcdnw_pkg::t_phase o_out
);
    import lcdnw_pkg::*;

    // init always runs a program, so the request side stalls next cycle
    a_init_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_req.cmd == CMD_INIT) |=> o_in_stall)
        else $error("init beat did not start a program");

    // an enable-high phase is always followed by an enable-low phase
    a_strobe_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out.enable_level)
        |=> (o_out_valid && !o_out.enable_level))
        else $error("enable strobe not released");

    // a request never ends with the strobe high
    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.last && o_out.enable_level))
        else $error("final phase leaves enable high");

    // a stalled phase holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled phase beat changed");

endmodule

bind char_lcd_nibble_writer_top lcdnw_checker u_lcdnw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
